@@ rtl/core/vfc_pkg.sv @@
// Shared types, constants, probe tables and control store for the voxel face culler.
package vfc_pkg;

	localparam int GRID_EDGE  = 32;
	localparam int BLOCK_BITS = 12;

	localparam int COORD_W  = 5;
	localparam int BLOCK_W  = 12;
	localparam int AXIS_W   = 2;
	localparam int EXT_W    = COORD_W + 2;
	localparam int ADDR_W   = 3 * COORD_W;
	localparam int MEM_W    = (BLOCK_BITS < BLOCK_W) ? BLOCK_BITS : BLOCK_W;
	localparam int PROBE_CNT = 6;
	localparam int STEP_W   = 4;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_X = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd2;

	localparam logic SIDE_NEG = 1'b0;
	localparam logic SIDE_POS = 1'b1;

	typedef logic [2:0]        probe_idx_t;
	typedef logic [STEP_W-1:0] step_t;
	typedef logic [EXT_W-1:0]  ext_coord_t;

	localparam probe_idx_t PROBE_XP   = 3'd0;
	localparam probe_idx_t PROBE_XN   = 3'd1;
	localparam probe_idx_t PROBE_YP   = 3'd2;
	localparam probe_idx_t PROBE_YN   = 3'd3;
	localparam probe_idx_t PROBE_ZP   = 3'd4;
	localparam probe_idx_t PROBE_ZN   = 3'd5;
	localparam probe_idx_t PROBE_SELF = 3'd6;

	localparam step_t STEP_FETCH   = 4'd0;
	localparam step_t STEP_RD_SELF = 4'd1;
	localparam step_t STEP_PROBE0  = 4'd2;
	localparam step_t STEP_PROBE1  = 4'd3;
	localparam step_t STEP_PROBE2  = 4'd4;
	localparam step_t STEP_PROBE3  = 4'd5;
	localparam step_t STEP_PROBE4  = 4'd6;
	localparam step_t STEP_PROBE5  = 4'd7;
	localparam step_t STEP_ARM     = 4'd8;
	localparam step_t STEP_EMIT    = 4'd9;

	typedef struct packed {
		logic               command;
		logic [COORD_W-1:0] voxel_x;
		logic [COORD_W-1:0] voxel_y;
		logic [COORD_W-1:0] voxel_z;
		logic [BLOCK_W-1:0] block_value;
	} cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] face_x;
		logic [COORD_W-1:0] face_y;
		logic [COORD_W-1:0] face_z;
		logic [BLOCK_W-1:0] face_block;
		logic [AXIS_W-1:0]  face_axis;
		logic               face_side;
		logic               has_face;
		logic               last_face;
	} face_t;

	typedef struct packed {
		ext_coord_t x;
		ext_coord_t y;
		ext_coord_t z;
	} nb_coord_t;

	typedef enum logic [1:0] {
		JMP_NEXT    = 2'd0,
		JMP_WAIT_IN = 2'd1,
		JMP_EMIT    = 2'd2,
		JMP_HOME    = 2'd3
	} jmp_t;

	typedef struct packed {
		logic       rd_en;
		logic       rd_self;
		probe_idx_t rd_idx;
		logic       cap_self;
		logic       cap_nb;
		probe_idx_t cap_idx;
		logic       arm_emit;
		jmp_t       jmp;
	} uop_t;

	typedef struct packed {
		uop_t              uop;
		logic              clearing;
		logic [ADDR_W-1:0] clr_addr;
		logic              in_acc;
		logic              emit_en;
	} ctl_t;

	typedef struct packed {
		logic emit_done;
	} stat_t;

	function automatic logic [AXIS_W-1:0] probe_axis(probe_idx_t k);
		logic [AXIS_W-1:0] a;
		unique case (k)
			PROBE_XP, PROBE_XN: a = AXIS_X;
			PROBE_YP, PROBE_YN: a = AXIS_Y;
			default:            a = AXIS_Z;
		endcase
		return a;
	endfunction

	function automatic logic probe_side(probe_idx_t k);
		return (k[0] == 1'b0) ? SIDE_POS : SIDE_NEG;
	endfunction

	function automatic nb_coord_t probe_coord(probe_idx_t k, cmd_t c);
		nb_coord_t n;
		n.x = EXT_W'(c.voxel_x);
		n.y = EXT_W'(c.voxel_y);
		n.z = EXT_W'(c.voxel_z);
		unique case (k)
			PROBE_XP: n.x = n.x + EXT_W'(1);
			PROBE_XN: n.x = n.x - EXT_W'(1);
			PROBE_YP: n.y = n.y + EXT_W'(1);
			PROBE_YN: n.y = n.y - EXT_W'(1);
			PROBE_ZP: n.z = n.z + EXT_W'(1);
			PROBE_ZN: n.z = n.z - EXT_W'(1);
			default:  n = n;
		endcase
		return n;
	endfunction

	function automatic logic coord_inside(nb_coord_t n);
		return (n.x < EXT_W'(GRID_EDGE)) && (n.y < EXT_W'(GRID_EDGE)) &&
			(n.z < EXT_W'(GRID_EDGE));
	endfunction

	function automatic uop_t ucode(step_t s);
		uop_t u;
		u = '0;
		u.jmp = JMP_NEXT;
		unique case (s)
			STEP_FETCH: u.jmp = JMP_WAIT_IN;
			STEP_RD_SELF: begin
				u.rd_en = 1'b1;
				u.rd_self = 1'b1;
			end
			STEP_PROBE0: begin
				u.rd_en = 1'b1;
				u.rd_idx = PROBE_XP;
				u.cap_self = 1'b1;
			end
			STEP_PROBE1: begin
				u.rd_en = 1'b1;
				u.rd_idx = PROBE_XN;
				u.cap_nb = 1'b1;
				u.cap_idx = PROBE_XP;
			end
			STEP_PROBE2: begin
				u.rd_en = 1'b1;
				u.rd_idx = PROBE_YP;
				u.cap_nb = 1'b1;
				u.cap_idx = PROBE_XN;
			end
			STEP_PROBE3: begin
				u.rd_en = 1'b1;
				u.rd_idx = PROBE_YN;
				u.cap_nb = 1'b1;
				u.cap_idx = PROBE_YP;
			end
			STEP_PROBE4: begin
				u.rd_en = 1'b1;
				u.rd_idx = PROBE_ZP;
				u.cap_nb = 1'b1;
				u.cap_idx = PROBE_YN;
			end
			STEP_PROBE5: begin
				u.rd_en = 1'b1;
				u.rd_idx = PROBE_ZN;
				u.cap_nb = 1'b1;
				u.cap_idx = PROBE_ZP;
			end
			STEP_ARM: begin
				u.cap_nb = 1'b1;
				u.cap_idx = PROBE_ZN;
				u.arm_emit = 1'b1;
			end
			STEP_EMIT: u.jmp = JMP_EMIT;
			default: u.jmp = JMP_HOME;
		endcase
		return u;
	endfunction

endpackage

@@ rtl/core/vfc_datapath.sv @@
// Voxel store, neighbour probing, face mask and output register for the face culler.
module vfc_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  vfc_pkg::ctl_t ctl,
	output vfc_pkg::stat_t stat,
	input  vfc_pkg::cmd_t cmd,
	output logic          face_valid,
	input  logic          face_ready,
	output vfc_pkg::face_t face
);

	logic [vfc_pkg::MEM_W-1:0] mem [2**vfc_pkg::ADDR_W];

	vfc_pkg::cmd_t            item_q;
	logic [vfc_pkg::MEM_W-1:0] rd_q;
	logic                      rd_inside_q;
	logic [vfc_pkg::BLOCK_W-1:0] self_q;
	logic [vfc_pkg::PROBE_CNT-1:0] air_q;
	logic [vfc_pkg::PROBE_CNT-1:0] air_nxt;
	logic [vfc_pkg::PROBE_CNT-1:0] pending_q;
	logic [vfc_pkg::PROBE_CNT-1:0] rest;
	logic                      empty_q;
	logic                      face_valid_q;
	vfc_pkg::face_t            face_q;
	vfc_pkg::face_t            rec;

	vfc_pkg::nb_coord_t        cmd_pos;
	vfc_pkg::nb_coord_t        rd_pos;
	logic [vfc_pkg::ADDR_W-1:0] rd_addr;
	logic [vfc_pkg::ADDR_W-1:0] wr_addr;
	logic [vfc_pkg::MEM_W-1:0] wr_data;
	logic                      we;
	logic                      cap_air;
	vfc_pkg::probe_idx_t       pick;
	logic                      slot_free;
	logic                      load;

	always_comb begin
		cmd_pos = vfc_pkg::probe_coord(vfc_pkg::PROBE_SELF, cmd);
		if (ctl.uop.rd_self) begin
			rd_pos = vfc_pkg::probe_coord(vfc_pkg::PROBE_SELF, item_q);
		end else begin
			rd_pos = vfc_pkg::probe_coord(ctl.uop.rd_idx, item_q);
		end
		rd_addr = {rd_pos.x[vfc_pkg::COORD_W-1:0], rd_pos.y[vfc_pkg::COORD_W-1:0],
			rd_pos.z[vfc_pkg::COORD_W-1:0]};
	end

	always_comb begin
		if (ctl.clearing) begin
			we = 1'b1;
			wr_addr = ctl.clr_addr;
			wr_data = '0;
		end else begin
			we = ctl.in_acc && (cmd.command == vfc_pkg::CMD_WRITE) &&
				vfc_pkg::coord_inside(cmd_pos);
			wr_addr = {cmd.voxel_x, cmd.voxel_y, cmd.voxel_z};
			wr_data = cmd.block_value[vfc_pkg::MEM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.uop.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		cap_air = !rd_inside_q || (rd_q == '0);
		air_nxt = air_q;
		if (ctl.uop.cap_nb) begin
			air_nxt[ctl.uop.cap_idx] = cap_air;
		end
	end

	always_comb begin
		pick = '0;
		for (int k = vfc_pkg::PROBE_CNT - 1; k >= 0; k--) begin
			if (pending_q[k]) begin
				pick = vfc_pkg::probe_idx_t'(k);
			end
		end
		rest = pending_q;
		rest[pick] = 1'b0;
	end

	always_comb begin
		rec.face_x = item_q.voxel_x;
		rec.face_y = item_q.voxel_y;
		rec.face_z = item_q.voxel_z;
		rec.face_block = self_q;
		if (empty_q) begin
			rec.face_axis = vfc_pkg::AXIS_Z;
			rec.face_side = vfc_pkg::SIDE_NEG;
			rec.has_face = 1'b0;
			rec.last_face = 1'b1;
		end else begin
			rec.face_axis = vfc_pkg::probe_axis(pick);
			rec.face_side = vfc_pkg::probe_side(pick);
			rec.has_face = 1'b1;
			rec.last_face = (rest == '0);
		end
	end

	assign slot_free = !face_valid_q || face_ready;
	assign load = ctl.emit_en && slot_free;
	assign stat.emit_done = load && (empty_q || (rest == '0));

	always_ff @(posedge clk) begin
		if (ctl.in_acc) begin
			item_q <= cmd;
		end
		if (ctl.uop.rd_en) begin
			rd_inside_q <= vfc_pkg::coord_inside(rd_pos);
		end
		if (ctl.uop.cap_self) begin
			self_q <= rd_inside_q ? vfc_pkg::BLOCK_W'(rd_q) : '0;
		end
		if (ctl.uop.cap_nb) begin
			air_q <= air_nxt;
		end
		if (ctl.uop.arm_emit) begin
			pending_q <= (self_q != '0) ? air_nxt : '0;
			empty_q <= (self_q == '0) || (air_nxt == '0);
		end else if (load && !empty_q) begin
			pending_q <= rest;
		end
		if (load) begin
			face_q <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_valid_q <= 1'b0;
		end else if (load) begin
			face_valid_q <= 1'b1;
		end else if (face_ready) begin
			face_valid_q <= 1'b0;
		end
	end

	assign face_valid = face_valid_q;
	assign face = face_q;

endmodule

@@ rtl/core/voxel_face_culler_unit.sv @@
// Top level of the voxel face culler: clearing pass, control store sequencer, datapath.
// Write item: written to the store as it is taken; the next item can be taken on the following cycle.
// Query item: the voxel and then its six neighbours are read in turn through the single
// store read port, then one face record per cycle (1 to 6) while the output is taken.
// Items are taken only at the fetch step; the output register frees the input side.
// Reset starts a clearing pass over all 32768 store entries with cmd_ready held low.
module voxel_face_culler_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  vfc_pkg::cmd_t  cmd,
	output logic           face_valid,
	input  logic           face_ready,
	output vfc_pkg::face_t face
);

	vfc_pkg::step_t              step_q;
	logic                        clear_q;
	logic [vfc_pkg::ADDR_W-1:0]  clr_addr_q;
	vfc_pkg::uop_t               uop;
	vfc_pkg::ctl_t               ctl;
	vfc_pkg::stat_t              stat;
	logic                        in_acc;

	assign uop = vfc_pkg::ucode(step_q);
	assign cmd_ready = !clear_q && (step_q == vfc_pkg::STEP_FETCH);
	assign in_acc = cmd_valid && cmd_ready;

	always_comb begin
		ctl.uop = uop;
		ctl.clearing = clear_q;
		ctl.clr_addr = clr_addr_q;
		ctl.in_acc = in_acc;
		ctl.emit_en = (uop.jmp == vfc_pkg::JMP_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clear_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= vfc_pkg::STEP_FETCH;
		end else begin
			unique case (uop.jmp)
				vfc_pkg::JMP_WAIT_IN: begin
					if (in_acc && (cmd.command == vfc_pkg::CMD_QUERY)) begin
						step_q <= step_q + 1'b1;
					end
				end
				vfc_pkg::JMP_EMIT: begin
					if (stat.emit_done) begin
						step_q <= vfc_pkg::STEP_FETCH;
					end
				end
				vfc_pkg::JMP_HOME: step_q <= vfc_pkg::STEP_FETCH;
				default: step_q <= step_q + 1'b1;
			endcase
		end
	end

	vfc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.cmd        (cmd),
		.face_valid (face_valid),
		.face_ready (face_ready),
		.face       (face)
	);

`ifndef SYNTHESIS
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (cmd.command == vfc_pkg::CMD_QUERY)) |=>
		(step_q == vfc_pkg::STEP_RD_SELF))
		else $error("query did not start the probe program");

	a_done_at_emit: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit_done |-> (step_q == vfc_pkg::STEP_EMIT))
		else $error("emission finished outside the emit step");

	a_quiet_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !face_valid)
		else $error("face item during clearing pass");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(face_valid && !face.has_face) |-> face.last_face)
		else $error("empty record not marked last");
`endif

endmodule

@@ dv/vfc_face_checker.sv @@
// Checker for the voxel face culler: models the voxel grid and compares face records.
`timescale 1ns / 1ps

module vfc_face_checker
	import vfc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	input  logic  cmd_ready,
	input  cmd_t  cmd,
	input  logic  face_valid,
	input  logic  face_ready,
	input  face_t face,
	output int    fail_count,
	output int    pending
);

	localparam int CELLS = GRID_EDGE * GRID_EDGE * GRID_EDGE;

	logic [MEM_W-1:0] voxel_grid [CELLS] = '{default: '0};
	face_t            faces_due [$];
	int               fails = 0;

	function automatic bit in_grid(int x, int y, int z);
		return x >= 0 && y >= 0 && z >= 0 && x < GRID_EDGE && y < GRID_EDGE && z < GRID_EDGE;
	endfunction

	function automatic int cell_of(int x, int y, int z);
		return (x * GRID_EDGE + y) * GRID_EDGE + z;
	endfunction

	function automatic int block_at(int x, int y, int z);
		if (!in_grid(x, y, z)) return 0;
		return int'(voxel_grid[cell_of(x, y, z)]);
	endfunction

	function automatic void cull_voxel(cmd_t c);
		int                x, y, z, own, hits, nx, ny, nz;
		probe_idx_t        p;
		logic [AXIS_W-1:0] ax;
		logic              sd;
		face_t             recs [PROBE_CNT];
		face_t             rec;
		x = int'(c.voxel_x);
		y = int'(c.voxel_y);
		z = int'(c.voxel_z);
		if (c.command == CMD_WRITE) begin
			if (in_grid(x, y, z))
				voxel_grid[cell_of(x, y, z)] = MEM_W'(c.block_value & ((1 << BLOCK_BITS) - 1));
			return;
		end
		own  = block_at(x, y, z);
		hits = 0;
		rec.face_x     = c.voxel_x;
		rec.face_y     = c.voxel_y;
		rec.face_z     = c.voxel_z;
		rec.face_block = BLOCK_W'(own);
		rec.face_axis  = AXIS_Z;
		rec.face_side  = SIDE_NEG;
		rec.has_face   = 1'b0;
		rec.last_face  = 1'b0;
		if (own != 0) begin
			for (int k = 0; k < PROBE_CNT; k++) begin
				p  = probe_idx_t'(k);
				nx = x;
				ny = y;
				nz = z;
				case (p)
					PROBE_XP: begin nx = x + 1; ax = AXIS_X; sd = SIDE_POS; end
					PROBE_XN: begin nx = x - 1; ax = AXIS_X; sd = SIDE_NEG; end
					PROBE_YP: begin ny = y + 1; ax = AXIS_Y; sd = SIDE_POS; end
					PROBE_YN: begin ny = y - 1; ax = AXIS_Y; sd = SIDE_NEG; end
					PROBE_ZP: begin nz = z + 1; ax = AXIS_Z; sd = SIDE_POS; end
					default:  begin nz = z - 1; ax = AXIS_Z; sd = SIDE_NEG; end
				endcase
				if (block_at(nx, ny, nz) == 0) begin
					recs[hits]           = rec;
					recs[hits].face_axis = ax;
					recs[hits].face_side = sd;
					recs[hits].has_face  = 1'b1;
					hits++;
				end
			end
		end
		if (hits == 0) begin
			rec.last_face = 1'b1;
			faces_due = {faces_due, rec};
		end else begin
			recs[hits-1].last_face = 1'b1;
			for (int k = 0; k < hits; k++) faces_due = {faces_due, recs[k]};
		end
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		face_t want;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) cull_voxel(cmd);
			if (face_valid && face_ready) begin
				if (faces_due.size() == 0) begin
					$error("face item with no record expected");
					fails++;
				end else begin
					want = faces_due.pop_front();
					check_field("face_x", want.face_x, face.face_x);
					check_field("face_y", want.face_y, face.face_y);
					check_field("face_z", want.face_z, face.face_z);
					check_field("face_block", want.face_block, face.face_block);
					check_field("face_axis", want.face_axis, face.face_axis);
					check_field("face_side", want.face_side, face.face_side);
					check_field("has_face", want.has_face, face.has_face);
					check_field("last_face", want.last_face, face.last_face);
				end
			end
		end
		pending    <= faces_due.size();
		fail_count <= fails;
	end

endmodule

@@ dv/tb.sv @@
// Testbench top for the voxel face culler: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
	import vfc_pkg::*;

	localparam int QUIET_LIMIT = 150000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_ITEMS  = 90;
	localparam int TOP         = GRID_EDGE - 1;

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  cmd_valid  = 1'b0;
	logic  cmd_ready;
	cmd_t  cmd        = '0;
	logic  face_valid;
	logic  face_ready = 1'b0;
	face_t face;

	int    fail_count;
	int    pending;
	int    quiet      = 0;
	bit    calm       = 1'b0;
	bit    hold_go    = 1'b0;
	bit    hold_done  = 1'b0;

	voxel_face_culler_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.face_valid (face_valid),
		.face_ready (face_ready),
		.face       (face)
	);

	vfc_face_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.face_valid (face_valid),
		.face_ready (face_ready),
		.face       (face),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	always begin
		@(posedge clk);
		if (hold_go && !hold_done) begin
			face_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_done = 1'b1;
		end else if (calm) begin
			face_ready <= 1'b1;
		end else begin
			face_ready <= ($urandom_range(99) >= 37);
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (face_valid && face_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("[voxel_face_culler_unit] ERROR");
			$finish;
		end
	end

	task automatic offer(cmd_t c);
		while (!calm && $urandom_range(99) < 37) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
	endtask

	task automatic put_voxel(int x, int y, int z, int v);
		cmd_t c;
		c.command     = CMD_WRITE;
		c.voxel_x     = COORD_W'(x);
		c.voxel_y     = COORD_W'(y);
		c.voxel_z     = COORD_W'(z);
		c.block_value = BLOCK_W'(v);
		offer(c);
	endtask

	task automatic ask_voxel(int x, int y, int z);
		cmd_t c;
		c.command     = CMD_QUERY;
		c.voxel_x     = COORD_W'(x);
		c.voxel_y     = COORD_W'(y);
		c.voxel_z     = COORD_W'(z);
		c.block_value = BLOCK_W'($urandom());
		offer(c);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [COORD_W-1:0] pick_coord(int base, bit near);
		if (near) return COORD_W'(base + $urandom_range(3));
		return COORD_W'($urandom_range(TOP));
	endfunction

	initial begin
		cmd_t c;
		int   bx, by, bz, r;
		bit   near;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		ask_voxel(0, 0, 0);
		put_voxel(0, 0, 0, 4095);
		ask_voxel(0, 0, 0);
		put_voxel(TOP, TOP, TOP, 1);
		ask_voxel(TOP, TOP, TOP);
		put_voxel(1, 0, 0, 5);
		ask_voxel(0, 0, 0);
		put_voxel(16, 16, 16, 'ha5a);
		put_voxel(17, 16, 16, 3);
		put_voxel(15, 16, 16, 'h800);
		put_voxel(16, 17, 16, 7);
		put_voxel(16, 15, 16, 'hfff);
		put_voxel(16, 16, 17, 'h5a5);
		put_voxel(16, 16, 15, 1);
		ask_voxel(16, 16, 16);
		put_voxel(16, 16, 17, 0);
		ask_voxel(16, 16, 16);
		ask_voxel(16, 16, 17);
		put_voxel(TOP, 0, TOP, 'h5a5);
		ask_voxel(TOP, 0, TOP);
		ask_voxel(0, TOP, 0);

		bx = 0;
		by = 0;
		bz = 0;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 12 == 0) begin
				r  = $urandom_range(2);
				bx = (r == 0) ? 0 : (r == 1) ? GRID_EDGE - 4 : $urandom_range(1, GRID_EDGE - 5);
				r  = $urandom_range(2);
				by = (r == 0) ? 0 : (r == 1) ? GRID_EDGE - 4 : $urandom_range(1, GRID_EDGE - 5);
				r  = $urandom_range(2);
				bz = (r == 0) ? 0 : (r == 1) ? GRID_EDGE - 4 : $urandom_range(1, GRID_EDGE - 5);
			end
			if (i == 25) hold_go = 1'b1;
			if (i == 50) drain();
			calm = (i >= 60 && i < 80);
			near = ($urandom_range(99) < 75);
			c.command = ($urandom_range(99) < 55) ? CMD_WRITE : CMD_QUERY;
			c.voxel_x = pick_coord(bx, near);
			c.voxel_y = pick_coord(by, near);
			c.voxel_z = pick_coord(bz, near);
			r = $urandom_range(99);
			if (r < 25) c.block_value = '0;
			else if (r < 35) c.block_value = '1;
			else c.block_value = BLOCK_W'($urandom());
			offer(c);
		end
		calm = 1'b0;

		drain();
		repeat (30) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[voxel_face_culler_unit] OK");
		end else begin
			$display("[voxel_face_culler_unit] ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/vfc_pkg.sv
rtl/core/vfc_datapath.sv
rtl/core/voxel_face_culler_unit.sv
dv/vfc_face_checker.sv
dv/tb.sv
